// ===== rtl/core/bqlp_pkg.sv =====
`default_nettype none

package bqlp_pkg;

  // Default build values for the top-level parameters.
  localparam int DefChannels = 4;
  localparam int DefFracBits = 16;

  // Configuration register file: one coefficient word per channel.
  localparam int NumRegs  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CoefW    = 61;
  localparam int CoefBitW = 20;
  localparam int EnableBit = 60;

  // Payload widths fixed by the stream format.
  localparam int ChanW   = 2;
  localparam int SampleW = 32;
  localparam int DelayW  = 40;
  localparam int SumW    = 42;
  localparam int ProdW   = CoefBitW + SumW;
  localparam int AccW    = 64;

  // Saturation limits of the output sample, held at accumulator width.
  localparam logic signed [AccW-1:0] SatMax = 64'sd2147483647;
  localparam logic signed [AccW-1:0] SatMin = -64'sd2147483648;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A1,
    ST_MUL_A2,
    ST_ROUND_W,
    ST_SUM,
    ST_MUL_B0,
    ST_DONE
  } bqlp_state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic take_item;
    logic mul_a1;
    logic mul_a2;
    logic round_w;
    logic sum;
    logic mul_b0;
    logic load_out;
  } bqlp_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic chan_on;
  } bqlp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bqlp_stream_if.sv =====
`default_nettype none

// Sample request channel into the filter.
interface bqlp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel;
  logic signed [31:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

// Filtered sample channel out of the filter.
interface bqlp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bqlp_ctrl.sv =====
`default_nettype none

module bqlp_ctrl
  import bqlp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         out_ready_i,
  input  wire bqlp_status_t status_i,
  output bqlp_cmd_t         cmd_o,
  output logic              in_ready_o,
  output logic              out_valid_o
);

  bqlp_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  logic        take;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign take        = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = status_i.chan_on ? ST_MUL_A1 : ST_DONE;
        end
      end
      ST_MUL_A1:  state_d = ST_MUL_A2;
      ST_MUL_A2:  state_d = ST_ROUND_W;
      ST_ROUND_W: state_d = ST_SUM;
      ST_SUM:     state_d = ST_MUL_B0;
      ST_MUL_B0:  state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:    cmd_o.take_item = take;
      ST_MUL_A1:  cmd_o.mul_a1    = 1'b1;
      ST_MUL_A2:  cmd_o.mul_a2    = 1'b1;
      ST_ROUND_W: cmd_o.round_w   = 1'b1;
      ST_SUM:     cmd_o.sum       = 1'b1;
      ST_MUL_B0:  cmd_o.mul_b0    = 1'b1;
      ST_DONE:    cmd_o.load_out  = slot_free;
      default:    cmd_o = '0;
    endcase
  end

  // The output register is full from a load until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The multiply sequence runs without gaps.
  a_seq_a1_a2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_A1) |=> (state_q == ST_MUL_A2))
    else $error("multiply sequence broken after a1 step");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // A disabled channel goes straight to the result step.
  a_bypass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take_item && !status_i.chan_on) |=> (state_q == ST_DONE))
    else $error("pass-through request did not bypass the filter");

  // A load always leaves a valid result behind.
  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== rtl/core/bqlp_datapath.sv =====
`default_nettype none

module bqlp_datapath
  import bqlp_pkg::*;
#(
  parameter int CHANNELS  = DefChannels,
  parameter int FRAC_BITS = DefFracBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [CoefW-1:0]          cfg_data_i,
  input  wire logic [ChanW-1:0]          channel_i,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire bqlp_cmd_t                 cmd_i,
  output bqlp_status_t                   status_o,
  output logic signed [SampleW-1:0]      sample_out_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [AccW-1:0] Half = AccW'(1) << (FRAC_BITS - 1);

  // Configuration and per-channel delay state.
  logic [CoefW-1:0]         coef_q [NumRegs];
  logic signed [DelayW-1:0] d1_q   [CHANNELS];
  logic signed [DelayW-1:0] d2_q   [CHANNELS];

  // Current request and working registers.
  logic [ChanW-1:0]          ch_q;
  logic [ChIdxW-1:0]         idx_q;
  logic signed [SampleW-1:0] x_q;
  logic                      pass_q;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [SumW-1:0]    ds_q, ds_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [DelayW-1:0]  w_q, w_d;
  logic signed [SumW-1:0]    s_q, s_d;
  logic signed [SampleW-1:0] sample_out_q, sample_out_d;

  logic [CoefW-1:0]            coef_sel;
  logic signed [CoefBitW-1:0]  coef_b0, coef_a1, coef_a2;
  logic signed [DelayW-1:0]    d1, d2;
  logic signed [SumW-1:0]      d1_ext, d2_ext;
  logic signed [AccW-1:0]      x_ext, prod_ext, acc_next, w_full, y_full;
  logic signed [CoefBitW-1:0]  mul_a;
  logic signed [SumW-1:0]      mul_b;

  // A channel is active when it exists and its enable bit is set.
  assign status_o.chan_on = (32'(channel_i) < CHANNELS) && coef_q[channel_i][EnableBit];

  // Coefficients and delays of the channel in progress.
  assign coef_sel = coef_q[ch_q];
  assign coef_b0  = coef_sel[CoefBitW-1:0];
  assign coef_a1  = coef_sel[2*CoefBitW-1:CoefBitW];
  assign coef_a2  = coef_sel[3*CoefBitW-1:2*CoefBitW];
  assign d1       = d1_q[idx_q];
  assign d2       = d2_q[idx_q];
  assign d1_ext   = {{(SumW-DelayW){d1[DelayW-1]}}, d1};
  assign d2_ext   = {{(SumW-DelayW){d2[DelayW-1]}}, d2};
  assign x_ext    = {{(AccW-SampleW){x_q[SampleW-1]}}, x_q};
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = coef_b0;
    mul_b = s_q;
    if (cmd_i.mul_a1) begin
      mul_a = coef_a1;
      mul_b = d1_ext;
    end else if (cmd_i.mul_a2) begin
      mul_a = coef_a2;
      mul_b = d2_ext;
    end
  end

  // Arithmetic for each step of the sequence.
  always_comb begin
    prod_d   = prod_q;
    ds_d     = ds_q;
    acc_d    = acc_q;
    w_d      = w_q;
    s_d      = s_q;
    acc_next = acc_q - prod_ext;
    w_full   = acc_next >>> FRAC_BITS;
    y_full   = (prod_ext + Half) >>> FRAC_BITS;
    if (cmd_i.mul_a1 || cmd_i.mul_a2 || cmd_i.mul_b0) begin
      prod_d = mul_a * mul_b;
    end
    if (cmd_i.mul_a1) begin
      ds_d = {d1_ext[SumW-2:0], 1'b0} + d2_ext;
    end
    // The rounding half is folded in before the products are taken off.
    if (cmd_i.mul_a2) begin
      acc_d = (x_ext <<< FRAC_BITS) + Half - prod_ext;
    end
    // An intermediate value beyond the delay range is replaced by the sample.
    if (cmd_i.round_w) begin
      if (w_full[AccW-1:DelayW-1] == {(AccW-DelayW+1){w_full[DelayW-1]}}) begin
        w_d = w_full[DelayW-1:0];
      end else begin
        w_d = {{(DelayW-SampleW){x_q[SampleW-1]}}, x_q};
      end
    end
    if (cmd_i.sum) begin
      s_d = {{(SumW-DelayW){w_q[DelayW-1]}}, w_q} + ds_q;
    end
  end

  // Result: saturated filter output, or the raw sample for a disabled channel.
  always_comb begin
    if (pass_q) begin
      sample_out_d = x_q;
    end else if (y_full > SatMax) begin
      sample_out_d = SatMax[SampleW-1:0];
    end else if (y_full < SatMin) begin
      sample_out_d = SatMin[SampleW-1:0];
    end else begin
      sample_out_d = y_full[SampleW-1:0];
    end
  end

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Delay line shifts once the new intermediate value is known.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (cmd_i.round_w) begin
      d2_q[idx_q] <= d1;
      d1_q[idx_q] <= w_d;
    end
  end

  // Request and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      ch_q   <= channel_i;
      idx_q  <= ChIdxW'(channel_i);
      x_q    <= sample_i;
      pass_q <= !status_o.chan_on;
    end
    prod_q <= prod_d;
    ds_q   <= ds_d;
    acc_q  <= acc_d;
    w_q    <= w_d;
    s_q    <= s_d;
    if (cmd_i.load_out) begin
      sample_out_q <= sample_out_d;
    end
  end

  assign sample_out_o = sample_out_q;

endmodule

`default_nettype wire

// ===== rtl/core/biquad_lowpass_multichannel_unit.sv =====
`default_nettype none

// Channel   Dir  Payload                                  Handshake
// in_i      in   channel[1:0], sample_in[31:0] Q16.16     valid/ready
// out_o     out  sample_out[31:0] Q16.16, saturated       valid/ready
// cfg       in   cfg_idx_i[1:0], cfg_data_i[60:0]         cfg_we_i, no wait
//
// An enabled channel goes from request to result through two multiply
// steps for the feedback terms, a rounding step, a sum and one multiply for
// the gain, all on one shared 20 x 42 bit multiplier, then the output load.
// A disabled or absent channel goes to the load. A new request is taken only
// in the idle state. Reset clears coefficients and delays at once. A result
// held in the output register stalls the sequencer at its final step only.

module biquad_lowpass_multichannel_unit
  import bqlp_pkg::*;
#(
  parameter int CHANNELS  = DefChannels,
  parameter int FRAC_BITS = DefFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CoefW-1:0]   cfg_data_i,
  bqlp_in_if.sink                 in_i,
  bqlp_out_if.source              out_o
);

  bqlp_cmd_t    cmd;
  bqlp_status_t status;

  // Sequencer.
  bqlp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  // Arithmetic, coefficients and per-channel state.
  bqlp_datapath #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .channel_i    (in_i.channel),
    .sample_i     (in_i.sample_in),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_out_o (out_o.sample_out)
  );

endmodule

`default_nettype wire

// ===== sim/biquad_lowpass_multichannel_unit_tb.sv =====
`timescale 1ns / 1ps

module biquad_lowpass_multichannel_unit_tb;
  import bqlp_pkg::*;

  localparam int FracBits    = DefFracBits;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 5000;
  localparam int PhaseItems  = 320;
  localparam int NumPhases   = 6;

  localparam logic signed [63:0] DelayMax = (64'sd1 <<< (DelayW - 1)) - 64'sd1;
  localparam logic signed [63:0] DelayMin = -(64'sd1 <<< (DelayW - 1));
  localparam logic signed [SampleW-1:0] SampleMax = 32'sh7fffffff;
  localparam logic signed [SampleW-1:0] SampleMin = 32'sh80000000;
  localparam int CoefMax = (1 <<< (CoefBitW - 1)) - 1;
  localparam int CoefMin = -(1 <<< (CoefBitW - 1));
  localparam int CoefOne = 1 <<< FracBits;

  // Channel codes used by the directed part.
  localparam logic [ChanW-1:0] Chan0 = 2'd0;
  localparam logic [ChanW-1:0] Chan1 = 2'd1;
  localparam logic [ChanW-1:0] Chan2 = 2'd2;
  localparam logic [ChanW-1:0] Chan3 = 2'd3;

  // Tracks per-channel filter state and holds the filtered samples still to arrive.
  class lowpass_scoreboard;
    logic [CoefW-1:0]         coef [NumRegs];
    logic signed [DelayW-1:0] delay_first [NumRegs];
    logic signed [DelayW-1:0] delay_second [NumRegs];
    logic signed [SampleW-1:0] expected_samples [$];
    int requests, results, enabled_requests, guard_hits, saturations, mismatches;

    function new();
      for (int i = 0; i < NumRegs; i++) begin
        coef[i] = '0;
        delay_first[i] = '0;
        delay_second[i] = '0;
      end
    endfunction

    function void set_coef(int idx, logic [CoefW-1:0] value);
      coef[idx] = value;
    endfunction

    // One step of the direct form II section, rounding half up at each product sum.
    function logic signed [SampleW-1:0] filter_sample(logic [ChanW-1:0] ch,
                                                      logic signed [SampleW-1:0] x);
      logic [CoefW-1:0] word;
      logic signed [63:0] b0, a1, a2, d1, d2, x64, acc, w, y;
      word = coef[ch];
      if (!word[EnableBit]) begin
        return x;
      end
      enabled_requests++;
      b0 = signed'(word[CoefBitW-1:0]);
      a1 = signed'(word[2*CoefBitW-1:CoefBitW]);
      a2 = signed'(word[3*CoefBitW-1:2*CoefBitW]);
      d1 = delay_first[ch];
      d2 = delay_second[ch];
      x64 = x;

      acc = (x64 <<< FracBits) - a1 * d1 - a2 * d2;
      w = (acc + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      // A runaway intermediate value is replaced by the sample itself.
      if (w > DelayMax || w < DelayMin) begin
        w = x64;
        guard_hits++;
      end

      acc = b0 * (w + (d1 <<< 1) + d2);
      y = (acc + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      if (y > SatMax) begin
        y = SatMax;
        saturations++;
      end else if (y < SatMin) begin
        y = SatMin;
        saturations++;
      end

      delay_second[ch] = d1[DelayW-1:0];
      delay_first[ch] = w[DelayW-1:0];
      return y[SampleW-1:0];
    endfunction

    function void note_request(logic [ChanW-1:0] ch, logic signed [SampleW-1:0] x);
      requests++;
      expected_samples.push_back(filter_sample(ch, x));
    endfunction

    function void check_sample(logic signed [SampleW-1:0] actual);
      logic signed [SampleW-1:0] want;
      results++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected result %0d (0x%08h)", $time, actual, actual);
        end
        return;
      end
      want = expected_samples.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] sample_out: expected %0d (0x%08h), got %0d (0x%08h)",
                   $time, want, want, actual, actual);
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CoefW-1:0] cfg_data_i;

  bqlp_in_if  req_ch ();
  bqlp_out_if res_ch ();

  biquad_lowpass_multichannel_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_ch),
    .out_o      (res_ch)
  );

  lowpass_scoreboard sb = new();

  bit idle_on;
  bit hold_req;
  int hold_count;
  int settings_written;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch both channels at each edge and give up if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.channel, req_ch.sample_in);
      end
      if (res_ch.valid && res_ch.ready) begin
        sb.check_sample(res_ch.sample_out);
      end
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 stall_cycles, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off when asked for.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_count++;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        res_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  function automatic logic [CoefW-1:0] pack_coef(bit en, int b0, int a1, int a2);
    return {en, a2[CoefBitW-1:0], a1[CoefBitW-1:0], b0[CoefBitW-1:0]};
  endfunction

  // Either a fully random word or a low-pass-like setting that is mostly stable.
  function automatic logic [CoefW-1:0] random_coef();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) begin
      return raw[CoefW-1:0];
    end
    return pack_coef($urandom_range(0, 9) != 0, $urandom_range(0, 20000),
                     -$urandom_range(30000, 125000), $urandom_range(5000, 60000));
  endfunction

  function automatic logic signed [SampleW-1:0] random_sample();
    logic signed [SampleW-1:0] s;
    s = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: s = SampleMax;
          1: s = SampleMin;
          2: s = '0;
          default: s = '1;
        endcase
      end
      1, 2, 3: s = s >>> $urandom_range(8, 24);
      default: ;
    endcase
    return s;
  endfunction

  // Writes all four coefficient words back to back; the block must be idle.
  task automatic program_coefs(input logic [CoefW-1:0] c0, input logic [CoefW-1:0] c1,
                               input logic [CoefW-1:0] c2, input logic [CoefW-1:0] c3);
    logic [CoefW-1:0] words [NumRegs];
    words = '{c0, c1, c2, c3};
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= words[i];
      sb.set_coef(i, words[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_written++;
  endtask

  // Offers one request and returns at the edge where it is taken.
  task automatic send_request(input logic [ChanW-1:0] ch, input logic signed [SampleW-1:0] x);
    if (idle_on && $urandom_range(0, 99) < 24) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.channel   <= ch;
    req_ch.sample_in <= x;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Stops offering and waits for every filtered sample, then lets the pipeline settle.
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int n, input bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 4) begin
        hold_req = 1'b1;
      end
      send_request(ChanW'($urandom_range(0, NumRegs - 1)), random_sample());
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_data_i       <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.channel   <= '0;
    req_ch.sample_in <= '0;
    idle_on = 1'b1;
    stall_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset every channel is off and passes samples straight through.
    send_request(Chan0, SampleMax);
    send_request(Chan1, SampleMin);
    send_request(Chan2, '0);
    send_request(Chan3, '1);
    send_request(Chan0, 32'sd1);
    send_request(Chan3, SampleMin);
    wait_drain();

    // A typical low-pass setting; channel 3 carries coefficients but stays off.
    program_coefs(pack_coef(1'b1, 4426, -74907, 27054), pack_coef(1'b1, 4426, -74907, 27054),
                  pack_coef(1'b1, 4426, -74907, 27054), pack_coef(1'b0, 4426, -74907, 27054));
    send_request(Chan0, SampleMax);
    send_request(Chan0, SampleMax);
    send_request(Chan0, SampleMin);
    send_request(Chan0, '0);
    send_request(Chan1, 32'sd1);
    send_request(Chan1, '1);
    send_request(Chan3, SampleMax);
    send_request(Chan3, 32'sd12345);
    send_request(Chan2, SampleMin);
    wait_drain();

    // Extreme coefficients: a runaway channel that trips the delay guard and
    // saturates, full-scale gains of both signs, and a unit-gain channel 3 whose
    // output shows that the off period left its delays at zero.
    program_coefs(pack_coef(1'b1, CoefMax, CoefMin, 0),
                  pack_coef(1'b1, CoefMin, CoefMax, CoefMin),
                  {1'b1, {(CoefW - 1){1'b1}}},
                  pack_coef(1'b1, CoefOne, 0, 0));
    repeat (5) send_request(Chan0, SampleMax);
    send_request(Chan1, SampleMin);
    send_request(Chan1, SampleMax);
    send_request(Chan2, SampleMax);
    send_request(Chan2, SampleMin);
    send_request(Chan3, 32'sd100);
    wait_drain();

    // Random settings and traffic; one phase runs without any idling and one
    // carries a long receiver hold-off while requests keep coming.
    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) begin
        program_coefs('0, {CoefW{1'b1}}, random_coef(), random_coef());
      end else begin
        program_coefs(random_coef(), random_coef(), random_coef(), random_coef());
      end
      idle_on = (p != 2);
      run_random_phase(PhaseItems, p == 1);
      wait_drain();
    end
    idle_on = 1'b1;

    $display("Run covered %0d requests, %0d through enabled channels, over %0d coefficient sets.",
             sb.requests, sb.enabled_requests, settings_written);
    $display("Delay guard fired %0d times, %0d outputs saturated, %0d long receiver hold-offs.",
             sb.guard_hits, sb.saturations, hold_count);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
